// ===== rtl/m64alu_pkg.sv =====
// Shared types, opcodes and helpers for the 64-bit integer ALU with register file.
package m64alu_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned REG_NUM  = 32;
  localparam int unsigned IMM_W    = 16;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 72;

  typedef enum logic [5:0] {
    OP_ADDI   = 6'd0,
    OP_DADDI  = 6'd1,
    OP_SLTI   = 6'd2,
    OP_SLTIU  = 6'd3,
    OP_ANDI   = 6'd4,
    OP_ORI    = 6'd5,
    OP_XORI   = 6'd6,
    OP_LUI    = 6'd7,
    OP_ADD    = 6'd8,
    OP_DADD   = 6'd9,
    OP_SUB    = 6'd10,
    OP_DSUB   = 6'd11,
    OP_AND    = 6'd12,
    OP_OR     = 6'd13,
    OP_XOR    = 6'd14,
    OP_NOR    = 6'd15,
    OP_SLT    = 6'd16,
    OP_SLTU   = 6'd17,
    OP_SLL    = 6'd18,
    OP_SRL    = 6'd19,
    OP_SRA    = 6'd20,
    OP_SLLV   = 6'd21,
    OP_SRLV   = 6'd22,
    OP_SRAV   = 6'd23,
    OP_DSLLV  = 6'd24,
    OP_DSRLV  = 6'd25,
    OP_DSRAV  = 6'd26,
    OP_DSLL   = 6'd27,
    OP_DSRL   = 6'd28,
    OP_DSRA   = 6'd29,
    OP_DSLL32 = 6'd30,
    OP_DSRL32 = 6'd31,
    OP_DSRA32 = 6'd32,
    OP_MOVZ   = 6'd33,
    OP_MOVN   = 6'd34,
    OP_MFHI   = 6'd35,
    OP_MTHI   = 6'd36,
    OP_MFLO   = 6'd37,
    OP_MTLO   = 6'd38
  } op_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_GPR  = 2'd1,
    TGT_HI   = 2'd2,
    TGT_LO   = 2'd3
  } tgt_e;

  typedef struct packed {
    logic [5:0]        action;
    logic [REG_AW-1:0] dest_reg;
    logic [REG_AW-1:0] first_src;
    logic [REG_AW-1:0] second_src;
    logic [IMM_W-1:0]  immediate;
    logic [4:0]        shift_amount;
  } instr_t;

  typedef struct packed {
    tgt_e              target;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   value;
  } res_t;

  typedef struct packed {
    logic en;
    res_t res;
  } wr_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    sx32 = {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  function automatic logic [XLEN-1:0] sx16(input logic [IMM_W-1:0] v);
    sx16 = {{(XLEN-IMM_W){v[IMM_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/m64alu_rf.sv =====
// General register file with HI/LO, registered read ports and write bypass.
module m64alu_rf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [m64alu_pkg::REG_AW-1:0] rs_i,
  input  logic [m64alu_pkg::REG_AW-1:0] rt_i,
  input  m64alu_pkg::wr_t               wr_i,
  output logic [m64alu_pkg::XLEN-1:0]   a_o,
  output logic [m64alu_pkg::XLEN-1:0]   b_o,
  output logic [m64alu_pkg::XLEN-1:0]   hi_o,
  output logic [m64alu_pkg::XLEN-1:0]   lo_o
);
  import m64alu_pkg::*;

  logic [XLEN-1:0]    mem [REG_NUM];
  logic [REG_NUM-1:0] vld_q;
  logic [XLEN-1:0]    mem_a_q, mem_b_q, byp_q, hi_q, lo_q;
  logic               vld_a_q, vld_b_q, hit_a_q, hit_b_q;
  logic               gpr_we, hit_a_d, hit_b_d;

  assign gpr_we  = wr_i.en && (wr_i.res.target == TGT_GPR);
  assign hit_a_d = gpr_we && (wr_i.res.idx == rs_i);
  assign hit_b_d = gpr_we && (wr_i.res.idx == rt_i);

  always_ff @(posedge clk_i) begin
    if (gpr_we) begin
      mem[wr_i.res.idx] <= wr_i.res.value;
    end
    if (rd_en_i) begin
      mem_a_q <= mem[rs_i];
      mem_b_q <= mem[rt_i];
      byp_q   <= wr_i.res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else begin
      if (gpr_we) begin
        vld_q[wr_i.res.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= vld_q[rs_i];
        vld_b_q <= vld_q[rt_i];
        hit_a_q <= hit_a_d;
        hit_b_q <= hit_b_d;
      end
      if (wr_i.en && (wr_i.res.target == TGT_HI)) begin
        hi_q <= wr_i.res.value;
      end
      if (wr_i.en && (wr_i.res.target == TGT_LO)) begin
        lo_q <= wr_i.res.value;
      end
    end
  end

  assign a_o  = hit_a_q ? byp_q : (vld_a_q ? mem_a_q : '0);
  assign b_o  = hit_b_q ? byp_q : (vld_b_q ? mem_b_q : '0);
  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

// ===== rtl/m64alu_exec.sv =====
// Combinational execute logic: adders, compares, shifters, moves.
module m64alu_exec (
  input  m64alu_pkg::instr_t          instr_i,
  input  logic [m64alu_pkg::XLEN-1:0] a_i,
  input  logic [m64alu_pkg::XLEN-1:0] b_i,
  input  logic [m64alu_pkg::XLEN-1:0] hi_i,
  input  logic [m64alu_pkg::XLEN-1:0] lo_i,
  output m64alu_pkg::res_t            res_o
);
  import m64alu_pkg::*;

  op_e             op;
  logic [XLEN-1:0] simm, zimm, sum_imm, sum_reg, diff;
  logic [XLEN-1:0] srl_src, sra_src, sll_r, srl_r, sra_r, val;
  logic [5:0]      amt;
  logic            same_reg, b_zero;
  tgt_e            tgt;

  assign op       = op_e'(instr_i.action);
  assign simm     = sx16(instr_i.immediate);
  assign zimm     = {{(XLEN-IMM_W){1'b0}}, instr_i.immediate};
  assign sum_imm  = a_i + simm;
  assign sum_reg  = a_i + b_i;
  assign diff     = a_i - b_i;
  assign same_reg = (instr_i.first_src == instr_i.dest_reg);
  assign b_zero   = (b_i == '0);

  always_comb begin
    case (op)
      OP_SLL, OP_SRL, OP_SRA, OP_DSLL, OP_DSRL, OP_DSRA: amt = {1'b0, instr_i.shift_amount};
      OP_DSLL32, OP_DSRL32, OP_DSRA32:                   amt = {1'b1, instr_i.shift_amount};
      OP_SLLV, OP_SRLV, OP_SRAV:                         amt = {1'b0, a_i[4:0]};
      default:                                           amt = a_i[5:0];
    endcase
  end

  assign srl_src = ((op == OP_SRL) || (op == OP_SRLV)) ? {{HALF_W{1'b0}}, b_i[HALF_W-1:0]} : b_i;
  assign sra_src = ((op == OP_SRA) || (op == OP_SRAV)) ? sx32(b_i) : b_i;
  assign sll_r   = b_i << amt;
  assign srl_r   = srl_src >> amt;
  assign sra_r   = $signed(sra_src) >>> amt;

  always_comb begin
    tgt = TGT_GPR;
    val = '0;
    case (op)
      OP_ADDI:   val = sx32(sum_imm);
      OP_DADDI:  val = sum_imm;
      OP_SLTI:   val = {{(XLEN-1){1'b0}}, ($signed(a_i) < $signed(simm))};
      OP_SLTIU:  val = {{(XLEN-1){1'b0}}, (a_i < simm)};
      OP_ANDI:   val = a_i & zimm;
      OP_ORI:    val = a_i | zimm;
      OP_XORI:   val = a_i ^ zimm;
      OP_LUI:    val = {{HALF_W{instr_i.immediate[IMM_W-1]}}, instr_i.immediate, {IMM_W{1'b0}}};
      OP_ADD:    val = sx32(sum_reg);
      OP_DADD:   val = sum_reg;
      OP_SUB:    val = sx32(diff);
      OP_DSUB:   val = diff;
      OP_AND:    val = a_i & b_i;
      OP_OR:     val = a_i | b_i;
      OP_XOR:    val = a_i ^ b_i;
      OP_NOR:    val = ~(a_i | b_i);
      OP_SLT:    val = {{(XLEN-1){1'b0}}, ($signed(a_i) < $signed(b_i))};
      OP_SLTU:   val = {{(XLEN-1){1'b0}}, (a_i < b_i)};
      OP_SLL, OP_SLLV:               val = sx32(sll_r);
      OP_SRL, OP_SRLV:               val = sx32(srl_r);
      OP_SRA, OP_SRAV:               val = sx32(sra_r);
      OP_DSLLV, OP_DSLL, OP_DSLL32:  val = sll_r;
      OP_DSRLV, OP_DSRL, OP_DSRL32:  val = srl_r;
      OP_DSRAV, OP_DSRA, OP_DSRA32:  val = sra_r;
      OP_MOVZ: begin
        if (b_zero && !same_reg) begin
          val = a_i;
        end else begin
          tgt = TGT_NONE;
        end
      end
      OP_MOVN: begin
        if (!b_zero && !same_reg) begin
          val = a_i;
        end else begin
          tgt = TGT_NONE;
        end
      end
      OP_MFHI:   val = hi_i;
      OP_MTHI: begin
        tgt = TGT_HI;
        val = a_i;
      end
      OP_MFLO:   val = lo_i;
      OP_MTLO: begin
        tgt = TGT_LO;
        val = a_i;
      end
      default:   tgt = TGT_NONE;
    endcase

    if ((tgt == TGT_GPR) && (instr_i.dest_reg == '0)) begin
      tgt = TGT_NONE;
    end

    res_o.target = tgt;
    res_o.idx    = (tgt == TGT_GPR) ? instr_i.dest_reg : '0;
    res_o.value  = (tgt == TGT_NONE) ? '0 : val;
  end

endmodule

// ===== rtl/mips64_integer_alu_with_regfile_core.sv =====
// Top level: input stage, register file, execute logic and result register.
//
//  channel  | dir | bits | fields (lsb first)
//  s_axis   | in  | 48   | action, dest_reg, first_src, second_src, immediate, shift_amount
//  m_axis   | out | 72   | write_target, write_reg, write_value
//
// An accepted instruction is held in the execute register, and its result then in the result
// register that drives m_axis; one instruction per cycle while m_axis is not stalled.
// The register file read is registered at input transfer; a write-back in the same
// cycle is bypassed into the read registers.
// Reset clears the register file valid bits, HI and LO; all GPRs read as zero.
// A stalled result holds the execute stage; input is taken whenever that stage frees.
module mips64_integer_alu_with_regfile_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // action, dest_reg, first_src, second_src, immediate, shift_amount, zero pad
  input  logic [m64alu_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // write_target, write_reg, write_value, zero pad
  output logic [m64alu_pkg::M_DATA_W-1:0]   m_axis_tdata_o
);
  import m64alu_pkg::*;

  instr_t          in_instr, ex_instr_q;
  logic            ex_vld_q, ex_adv, in_xfer, out_vld_q;
  res_t            ex_res, out_res_q;
  wr_t             wr;
  logic [XLEN-1:0] a, b, hi, lo;

  assign in_instr.action       = s_axis_tdata_i[5:0];
  assign in_instr.dest_reg     = s_axis_tdata_i[10:6];
  assign in_instr.first_src    = s_axis_tdata_i[15:11];
  assign in_instr.second_src   = s_axis_tdata_i[20:16];
  assign in_instr.immediate    = s_axis_tdata_i[36:21];
  assign in_instr.shift_amount = s_axis_tdata_i[41:37];

  assign ex_adv          = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !ex_vld_q || ex_adv;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign wr.en  = ex_vld_q && ex_adv;
  assign wr.res = ex_res;

  m64alu_rf u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_xfer),
    .rs_i    (in_instr.first_src),
    .rt_i    (in_instr.second_src),
    .wr_i    (wr),
    .a_o     (a),
    .b_o     (b),
    .hi_o    (hi),
    .lo_o    (lo)
  );

  m64alu_exec u_exec (
    .instr_i (ex_instr_q),
    .a_i     (a),
    .b_i     (b),
    .hi_i    (hi),
    .lo_i    (lo),
    .res_o   (ex_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        ex_vld_q <= 1'b1;
      end else if (ex_adv) begin
        ex_vld_q <= 1'b0;
      end
      if (ex_vld_q && ex_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ex_instr_q <= in_instr;
    end
    if (ex_vld_q && ex_adv) begin
      out_res_q <= ex_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q.value, out_res_q.idx, out_res_q.target};

endmodule

// ===== rtl/m64alu_checker.sv =====
// Port-level assertions for the ALU core, bound to the top level.
module m64alu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_i,
  input logic                            m_axis_tvalid_i,
  input logic                            m_axis_tready_i,
  input logic [m64alu_pkg::M_DATA_W-1:0] m_axis_tdata_i
);
  import m64alu_pkg::*;

  logic [1:0] tgt;
  logic [4:0] widx;
  logic [63:0] wval;

  assign tgt  = m_axis_tdata_i[1:0];
  assign widx = m_axis_tdata_i[6:2];
  assign wval = m_axis_tdata_i[70:7];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (tgt == TGT_NONE) |-> (widx == '0) && (wval == '0))
    else $error("no-write result carries data");

  a_reg_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> ((tgt == TGT_GPR) && (widx != '0)) ||
                        ((tgt != TGT_GPR) && (widx == '0)))
    else $error("write_reg inconsistent with write_target");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_i) |-> $past(s_axis_tvalid_i && s_axis_tready_i, 2))
    else $error("result without matching input transfer");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_i |-> s_axis_tready_i)
    else $error("input stalled with empty output");

endmodule

bind mips64_integer_alu_with_regfile_core m64alu_checker u_m64alu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

// ===== dv/testbench.sv =====
// Testbench for the 64-bit integer ALU with register file: directed, random and stall tests.
`timescale 1ns / 1ps

module testbench;
  import m64alu_pkg::*;

  localparam int unsigned     HALF_PERIOD = 2;
  localparam int unsigned     IDLE_PCT    = 28;
  localparam int unsigned     TIMEOUT_NS  = 400_000;
  localparam int unsigned     HOLD_LEN    = 80;
  localparam logic [5:0]      ACT_MAX     = 6'd63;

  typedef struct {
    tgt_e              target;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   value;
  } writeback_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [S_DATA_W-1:0] s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata_o;

  logic [XLEN-1:0] gpr_model [REG_NUM];
  logic [XLEN-1:0] hi_model = '0;
  logic [XLEN-1:0] lo_model = '0;
  writeback_t      writeback_q [$];
  int unsigned     fail_count = 0;
  int unsigned     hold_cycles = 0;
  bit              calm = 1'b0;

  mips64_integer_alu_with_regfile_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [XLEN-1:0] sext_word(input logic [XLEN-1:0] v);
    return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  function automatic writeback_t execute_instr(input instr_t ins);
    writeback_t  wb;
    logic [XLEN-1:0] a, b, simm, zimm, val;
    tgt_e        tgt;
    a    = gpr_model[ins.first_src];
    b    = gpr_model[ins.second_src];
    simm = {{(XLEN-IMM_W){ins.immediate[IMM_W-1]}}, ins.immediate};
    zimm = {{(XLEN-IMM_W){1'b0}}, ins.immediate};
    tgt  = TGT_GPR;
    val  = '0;
    case (ins.action)
      OP_ADDI:   val = sext_word(a + simm);
      OP_DADDI:  val = a + simm;
      OP_SLTI:   val = ($signed(a) < $signed(simm)) ? 64'd1 : 64'd0;
      OP_SLTIU:  val = (a < simm) ? 64'd1 : 64'd0;
      OP_ANDI:   val = a & zimm;
      OP_ORI:    val = a | zimm;
      OP_XORI:   val = a ^ zimm;
      OP_LUI:    val = sext_word(zimm << IMM_W);
      OP_ADD:    val = sext_word(a + b);
      OP_DADD:   val = a + b;
      OP_SUB:    val = sext_word(a - b);
      OP_DSUB:   val = a - b;
      OP_AND:    val = a & b;
      OP_OR:     val = a | b;
      OP_XOR:    val = a ^ b;
      OP_NOR:    val = ~(a | b);
      OP_SLT:    val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      OP_SLTU:   val = (a < b) ? 64'd1 : 64'd0;
      OP_SLL:    val = sext_word({32'b0, b[31:0]} << ins.shift_amount);
      OP_SRL:    val = sext_word({32'b0, b[31:0]} >> ins.shift_amount);
      OP_SRA:    val = sext_word($signed(sext_word(b)) >>> ins.shift_amount);
      OP_SLLV:   val = sext_word({32'b0, b[31:0]} << a[4:0]);
      OP_SRLV:   val = sext_word({32'b0, b[31:0]} >> a[4:0]);
      OP_SRAV:   val = sext_word($signed(sext_word(b)) >>> a[4:0]);
      OP_DSLLV:  val = b << a[5:0];
      OP_DSRLV:  val = b >> a[5:0];
      OP_DSRAV:  val = $signed(b) >>> a[5:0];
      OP_DSLL:   val = b << ins.shift_amount;
      OP_DSRL:   val = b >> ins.shift_amount;
      OP_DSRA:   val = $signed(b) >>> ins.shift_amount;
      OP_DSLL32: val = b << (ins.shift_amount + 32);
      OP_DSRL32: val = b >> (ins.shift_amount + 32);
      OP_DSRA32: val = $signed(b) >>> (ins.shift_amount + 32);
      OP_MOVZ: begin
        if (b == '0 && ins.first_src != ins.dest_reg) val = a;
        else tgt = TGT_NONE;
      end
      OP_MOVN: begin
        if (b != '0 && ins.first_src != ins.dest_reg) val = a;
        else tgt = TGT_NONE;
      end
      OP_MFHI:   val = hi_model;
      OP_MTHI: begin
        tgt = TGT_HI;
        val = a;
      end
      OP_MFLO:   val = lo_model;
      OP_MTLO: begin
        tgt = TGT_LO;
        val = a;
      end
      default:   tgt = TGT_NONE;
    endcase
    if (tgt == TGT_GPR && ins.dest_reg == '0) tgt = TGT_NONE;
    case (tgt)
      TGT_GPR: gpr_model[ins.dest_reg] = val;
      TGT_HI:  hi_model = val;
      TGT_LO:  lo_model = val;
      default: val = '0;
    endcase
    wb.target = tgt;
    wb.idx    = (tgt == TGT_GPR) ? ins.dest_reg : '0;
    wb.value  = val;
    return wb;
  endfunction

  function automatic instr_t instr_of(input logic [5:0] act, input logic [4:0] rd,
                                      input logic [4:0] rs, input logic [4:0] rt,
                                      input logic [15:0] imm, input logic [4:0] sa);
    instr_t ins;
    ins.action       = act;
    ins.dest_reg     = rd;
    ins.first_src    = rs;
    ins.second_src   = rt;
    ins.immediate    = imm;
    ins.shift_amount = sa;
    return ins;
  endfunction

  // half the picks come from a small pool so results feed back quickly
  function automatic logic [4:0] pick_reg();
    return $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom());
  endfunction

  function automatic instr_t rand_instr();
    instr_t      ins;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) ins.action = 6'($urandom_range(OP_MTLO + 1, ACT_MAX));
    else if (pick < 15) ins.action = OP_LUI;
    else if (pick < 22) ins.action = OP_ORI;
    else ins.action = 6'($urandom_range(0, OP_MTLO));
    ins.dest_reg   = pick_reg();
    ins.first_src  = pick_reg();
    ins.second_src = pick_reg();
    case ($urandom_range(0, 7))
      0:       ins.immediate = 16'h0000;
      1:       ins.immediate = 16'hFFFF;
      2:       ins.immediate = 16'h8000;
      3:       ins.immediate = 16'h7FFF;
      default: ins.immediate = 16'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       ins.shift_amount = 5'd0;
      1:       ins.shift_amount = 5'd31;
      default: ins.shift_amount = 5'($urandom());
    endcase
    return ins;
  endfunction

  // returns at the rising edge of the transfer; valid stays up for the next call
  task automatic send_instr(input instr_t ins);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_DATA_W-42){1'b0}}, ins.shift_amount, ins.immediate,
                        ins.second_src, ins.first_src, ins.dest_reg, ins.action};
    do @(posedge clk_i); while (!s_axis_tready_o);
    writeback_q.push_back(execute_instr(ins));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (writeback_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    writeback_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (writeback_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o[70:7], '0);
      end else begin
        want = writeback_q.pop_front();
        if (m_axis_tdata_o[1:0] != want.target)
          report_mismatch("write_target", m_axis_tdata_o[1:0], want.target);
        if (m_axis_tdata_o[6:2] != want.idx)
          report_mismatch("write_reg", m_axis_tdata_o[6:2], want.idx);
        if (m_axis_tdata_o[70:7] != want.value)
          report_mismatch("write_value", m_axis_tdata_o[70:7], want.value);
      end
    end
  end

  // every op, field extremes, r0 writes, conditional moves, HI/LO and unused codes
  task automatic test_directed();
    send_instr(instr_of(OP_LUI,    5'd1,  5'd0,  5'd0,  16'h8000, 5'd0));
    send_instr(instr_of(OP_ORI,    5'd1,  5'd1,  5'd0,  16'hFFFF, 5'd0));
    send_instr(instr_of(OP_DADDI,  5'd2,  5'd0,  5'd0,  16'hFFFF, 5'd0));
    send_instr(instr_of(OP_ADDI,   5'd3,  5'd0,  5'd0,  16'h7FFF, 5'd0));
    send_instr(instr_of(OP_DSLL32, 5'd4,  5'd0,  5'd2,  16'h0000, 5'd31));
    send_instr(instr_of(OP_ADDI,   5'd5,  5'd1,  5'd0,  16'h8000, 5'd0));
    send_instr(instr_of(OP_DADD,   5'd6,  5'd4,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_ADD,    5'd7,  5'd1,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SUB,    5'd8,  5'd4,  5'd3,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSUB,   5'd9,  5'd4,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_ANDI,   5'd10, 5'd2,  5'd0,  16'hFFFF, 5'd0));
    send_instr(instr_of(OP_XORI,   5'd11, 5'd1,  5'd0,  16'hA5A5, 5'd0));
    send_instr(instr_of(OP_AND,    5'd12, 5'd1,  5'd6,  16'h0000, 5'd0));
    send_instr(instr_of(OP_OR,     5'd13, 5'd3,  5'd4,  16'h0000, 5'd0));
    send_instr(instr_of(OP_XOR,    5'd14, 5'd1,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_NOR,    5'd15, 5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SLT,    5'd16, 5'd4,  5'd3,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SLTU,   5'd17, 5'd4,  5'd3,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SLTI,   5'd18, 5'd4,  5'd0,  16'h8000, 5'd0));
    send_instr(instr_of(OP_SLTIU,  5'd19, 5'd3,  5'd0,  16'hFFFF, 5'd0));
    send_instr(instr_of(OP_SLL,    5'd20, 5'd0,  5'd1,  16'h0000, 5'd31));
    send_instr(instr_of(OP_SRL,    5'd21, 5'd0,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SRA,    5'd22, 5'd0,  5'd1,  16'h0000, 5'd31));
    send_instr(instr_of(OP_SLLV,   5'd23, 5'd3,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SRLV,   5'd24, 5'd2,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_SRAV,   5'd25, 5'd2,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSLLV,  5'd26, 5'd2,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSRLV,  5'd27, 5'd2,  5'd4,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSRAV,  5'd28, 5'd2,  5'd4,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSLL,   5'd29, 5'd0,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DSRL,   5'd30, 5'd0,  5'd4,  16'h0000, 5'd31));
    send_instr(instr_of(OP_DSRA,   5'd31, 5'd0,  5'd4,  16'h0000, 5'd31));
    send_instr(instr_of(OP_DSRL32, 5'd20, 5'd0,  5'd4,  16'h0000, 5'd31));
    send_instr(instr_of(OP_DSRA32, 5'd21, 5'd0,  5'd4,  16'h0000, 5'd31));
    send_instr(instr_of(OP_DSRA32, 5'd22, 5'd0,  5'd1,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MOVZ,   5'd23, 5'd1,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MOVZ,   5'd24, 5'd1,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MOVN,   5'd25, 5'd4,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MOVN,   5'd1,  5'd1,  5'd2,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MOVN,   5'd26, 5'd4,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MTHI,   5'd0,  5'd1,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MTLO,   5'd0,  5'd4,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MFHI,   5'd27, 5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MFLO,   5'd28, 5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MTHI,   5'd0,  5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_MFHI,   5'd29, 5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(OP_DADDI,  5'd0,  5'd2,  5'd0,  16'hFFFF, 5'd0));
    send_instr(instr_of(OP_OR,     5'd30, 5'd0,  5'd0,  16'h0000, 5'd0));
    send_instr(instr_of(ACT_MAX,   5'd31, 5'd31, 5'd31, 16'hFFFF, 5'd31));
    send_instr(instr_of(6'(OP_MTLO + 1), 5'd31, 5'd1, 5'd1, 16'h0000, 5'd0));
    wait_drained();
  endtask

  task automatic test_random_mix();
    repeat (700) send_instr(rand_instr());
    wait_drained();
  endtask

  // no idling on either side; register picks lean on a small pool so results feed back often
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (150) send_instr(rand_instr());
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_LEN;
    repeat (50) send_instr(rand_instr());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < REG_NUM; i++) gpr_model[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix();
    test_back_to_back();
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== mips64_integer_alu_with_regfile_core.f =====
rtl/m64alu_pkg.sv
rtl/m64alu_rf.sv
rtl/m64alu_exec.sv
rtl/mips64_integer_alu_with_regfile_core.sv
rtl/m64alu_checker.sv
dv/testbench.sv
